[hw/rtl/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the track chunk parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int QueueDepth = 4;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_DELTA    = 4'd1,
        PH_STATUS   = 4'd2,
        PH_DATA1    = 4'd3,
        PH_DATA2    = 4'd4,
        PH_METATYPE = 4'd5,
        PH_LENGTH   = 4'd6,
        PH_PAYLOAD  = 4'd7
    } phase_t;

    localparam logic [1:0] REC_EVENT   = 2'd0;
    localparam logic [1:0] REC_PAYLOAD = 2'd1;
    localparam logic [1:0] REC_END     = 2'd2;

    localparam logic [7:0] STATUS_MIN  = 8'h80;
    localparam logic [7:0] SYSTEM_MIN  = 8'hF0;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_ESC   = 8'hF7;
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [6:0] VLQ_MASK    = 7'h7F;

    // one record as it travels from front to back
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [3:0]  event_kind;
        logic [7:0]  status_byte;
        logic [7:0]  meta_code;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic [31:0] delta_ticks;
        logic [31:0] payload_length;
        logic [7:0]  payload_value;
        logic [31:0] chunk_bytes;
        logic        last;
    } record_t;

    function automatic logic [3:0] kind_of(input logic [7:0] st);
        logic [3:0] k;
        k = 4'd0;
        if (st >= STATUS_MIN && st < SYSTEM_MIN)
            k = {1'b0, st[6:4]} + 4'd1;
        else if (st == SYSEX_START || st == SYSEX_ESC)
            k = 4'd8;
        else if (st == META_STATUS)
            k = 4'd9;
        return k;
    endfunction

    function automatic logic one_data_byte(input logic [7:0] st);
        return (st[7:4] == 4'hC) || (st[7:4] == 4'hD);
    endfunction

endpackage

[hw/rtl/mtep_front.sv]
// ----------------------------------------------------------------------------
// mtep_front
// Byte parser: walks the chunk state and produces up to two records a byte.
// ----------------------------------------------------------------------------
module mtep_front
    import mtep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        rec_valid,
    input  logic        rec_ready,
    output record_t     rec_data
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [31:0] decl_reg, decl_next;
    logic [31:0] cons_reg, cons_next;
    logic [7:0]  run_reg, run_next;
    logic [31:0] delta_reg, delta_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  meta_reg, meta_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] prem_reg, prem_next;
    // second record waiting from the previous byte
    logic        pend_reg, pend_next;
    record_t     pendrec_reg, pendrec_next;

    logic        n_first, n_end, boundary, take;
    record_t     rec0, rec_end;
    logic [31:0] vlq_len;
    logic [7:0]  b;

    assign b        = data_byte;
    assign in_ready = !pend_reg && rec_ready;
    assign take     = in_valid && in_ready;

    // next state and records
    always_comb
    begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        decl_next  = decl_reg;
        cons_next  = cons_reg;
        run_next   = run_reg;
        delta_next = delta_reg;
        cur_next   = cur_reg;
        meta_next  = meta_reg;
        held_next  = held_reg;
        prem_next  = prem_reg;
        n_first    = 1'b0;
        n_end      = 1'b0;
        boundary   = 1'b0;
        rec0       = '0;
        rec_end    = '0;
        vlq_len    = {prem_reg[24:0], b[6:0] & VLQ_MASK};
        if (phase_reg != PH_HEADER && cons_reg != '1)
            cons_next = cons_reg + 32'd1;
        unique case (phase_reg)
            PH_DELTA:
            begin
                delta_next = {delta_reg[24:0], b[6:0]};
                if (!b[7])
                    phase_next = PH_STATUS;
            end
            PH_STATUS:
            begin
                meta_next = '0;
                if (b[7]) begin
                    cur_next = b;
                    if (b < SYSTEM_MIN) begin
                        run_next   = b;
                        phase_next = PH_DATA1;
                    end else if (b == SYSEX_START || b == SYSEX_ESC) begin
                        prem_next  = '0;
                        phase_next = PH_LENGTH;
                    end else if (b == META_STATUS) begin
                        phase_next = PH_METATYPE;
                    end else begin
                        n_first = 1'b1;
                        rec0.status_byte = b;
                        rec0.delta_ticks = delta_reg;
                        rec0.last = 1'b1;
                        boundary = 1'b1;
                    end
                end else if (run_reg != '0) begin
                    cur_next  = run_reg;
                    held_next = b;
                    if (one_data_byte(run_reg)) begin
                        n_first = 1'b1;
                        rec0.event_kind  = kind_of(run_reg);
                        rec0.status_byte = run_reg;
                        rec0.first_value = b;
                        rec0.delta_ticks = delta_reg;
                        rec0.last = 1'b1;
                        boundary = 1'b1;
                    end else begin
                        phase_next = PH_DATA2;
                    end
                end else begin
                    cur_next = '0;
                    n_first = 1'b1;
                    rec0.first_value = b;
                    rec0.delta_ticks = delta_reg;
                    rec0.last = 1'b1;
                    boundary = 1'b1;
                end
            end
            PH_DATA1:
            begin
                held_next = b;
                if (one_data_byte(cur_reg)) begin
                    n_first = 1'b1;
                    rec0.event_kind  = kind_of(cur_reg);
                    rec0.status_byte = cur_reg;
                    rec0.first_value = b;
                    rec0.delta_ticks = delta_reg;
                    rec0.last = 1'b1;
                    boundary = 1'b1;
                end else begin
                    phase_next = PH_DATA2;
                end
            end
            PH_DATA2:
            begin
                n_first = 1'b1;
                rec0.event_kind   = kind_of(cur_reg);
                rec0.status_byte  = cur_reg;
                rec0.first_value  = held_reg;
                rec0.second_value = b;
                rec0.delta_ticks  = delta_reg;
                rec0.last = 1'b1;
                boundary = 1'b1;
            end
            PH_METATYPE:
            begin
                meta_next  = b;
                prem_next  = '0;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                prem_next = vlq_len;
                if (!b[7]) begin
                    n_first = 1'b1;
                    rec0.event_kind     = kind_of(cur_reg);
                    rec0.status_byte    = cur_reg;
                    rec0.meta_code      = meta_reg;
                    rec0.delta_ticks    = delta_reg;
                    rec0.payload_length = vlq_len;
                    rec0.last = (vlq_len == '0);
                    if (vlq_len == '0)
                        boundary = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (prem_reg != '0)
                    prem_next = prem_reg - 32'd1;
                n_first = 1'b1;
                rec0.record_kind   = REC_PAYLOAD;
                rec0.event_kind    = kind_of(cur_reg);
                rec0.status_byte   = cur_reg;
                rec0.meta_code     = meta_reg;
                rec0.delta_ticks   = delta_reg;
                rec0.payload_value = b;
                rec0.last = (prem_next == '0);
                boundary  = (prem_next == '0);
            end
            default:
            begin
                phase_next = PH_HEADER;
                if (hidx_reg[2])
                    decl_next = {decl_reg[23:0], b};
                if (hidx_reg == 3'd7) begin
                    hidx_next = '0;
                    cons_next = '0;
                    if (decl_next == '0) begin
                        n_first = 1'b1;
                        rec0.record_kind = REC_END;
                        rec0.last = 1'b1;
                    end else begin
                        delta_next = '0;
                        phase_next = PH_DELTA;
                    end
                end else begin
                    hidx_next = hidx_reg + 3'd1;
                end
            end
        endcase
        if (boundary) begin
            if (cons_next >= decl_reg) begin
                n_end = 1'b1;
                rec_end.record_kind = REC_END;
                rec_end.chunk_bytes = decl_reg;
                rec_end.last = 1'b1;
                phase_next = PH_HEADER;
                hidx_next  = '0;
            end else begin
                delta_next = '0;
                phase_next = PH_DELTA;
            end
        end
    end

    // output selection
    always_comb
    begin
        pend_next    = pend_reg;
        pendrec_next = pendrec_reg;
        rec_valid    = 1'b0;
        rec_data     = rec0;
        if (pend_reg) begin
            rec_valid = 1'b1;
            rec_data  = pendrec_reg;
            if (rec_ready)
                pend_next = 1'b0;
        end else if (take) begin
            if (n_first) begin
                rec_valid = 1'b1;
                rec_data  = rec0;
                if (n_end) begin
                    pend_next    = 1'b1;
                    pendrec_next = rec_end;
                end
            end else if (n_end) begin
                rec_valid = 1'b1;
                rec_data  = rec_end;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            decl_reg  <= '0;
            cons_reg  <= '0;
            run_reg   <= '0;
            delta_reg <= '0;
            cur_reg   <= '0;
            meta_reg  <= '0;
            held_reg  <= '0;
            prem_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (take) begin
                phase_reg <= phase_next;
                hidx_reg  <= hidx_next;
                decl_reg  <= decl_next;
                cons_reg  <= cons_next;
                run_reg   <= run_next;
                delta_reg <= delta_next;
                cur_reg   <= cur_next;
                meta_reg  <= meta_next;
                held_reg  <= held_next;
                prem_reg  <= prem_next;
            end
        end
    end

    // pending record payload
    always_ff @(posedge clk)
    begin
        pendrec_reg <= pendrec_next;
    end

endmodule

[hw/rtl/mtep_queue.sv]
// ----------------------------------------------------------------------------
// mtep_queue
// Record queue between the parser and the output side.
// ----------------------------------------------------------------------------
module mtep_queue
    import mtep_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  record_t wr_data,
    output logic    rd_valid,
    input  logic    rd_ready,
    output record_t rd_data
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    record_t         mem_reg [Depth];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     cnt_reg;
    logic            wr_en, rd_en;

    assign wr_ready = (cnt_reg != AW'(0) + (AW+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (wr_en)
                wptr_reg <= (wptr_reg == AW'(Depth - 1)) ? '0 : wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= (rptr_reg == AW'(Depth - 1)) ? '0 : rptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule

[hw/rtl/midi_track_event_parser_core.sv]
// Latency: a byte's first record can leave the cycle after the byte is taken.
// Throughput: one byte per cycle unless the queue is full; a byte that yields
// an event and the end record holds the input while the second record issues.
// A 4-entry record queue decouples the parser from the output handshake.
// Reset: asynchronous, active low; parser returns to chunk header, queue empty.
// ----------------------------------------------------------------------------
// midi_track_event_parser_core
// Track chunk byte parser producing event, payload and end records.
// ----------------------------------------------------------------------------
module midi_track_event_parser_core
    import mtep_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  record_kind,
    output logic [3:0]  event_kind,
    output logic [7:0]  status_byte,
    output logic [7:0]  meta_code,
    output logic [7:0]  first_value,
    output logic [7:0]  second_value,
    output logic [31:0] delta_ticks,
    output logic [31:0] payload_length,
    output logic [7:0]  payload_value,
    output logic [31:0] chunk_bytes,
    output logic        last
);

    logic    rec_valid, rec_ready;
    record_t rec_data, q_data;

    mtep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_data  (rec_data)
    );

    mtep_queue #(.Depth(Depth)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (rec_valid),
        .wr_ready (rec_ready),
        .wr_data  (rec_data),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (q_data)
    );

    // unpack record fields
    assign record_kind    = q_data.record_kind;
    assign event_kind     = q_data.event_kind;
    assign status_byte    = q_data.status_byte;
    assign meta_code      = q_data.meta_code;
    assign first_value    = q_data.first_value;
    assign second_value   = q_data.second_value;
    assign delta_ticks    = q_data.delta_ticks;
    assign payload_length = q_data.payload_length;
    assign payload_value  = q_data.payload_value;
    assign chunk_bytes    = q_data.chunk_bytes;
    assign last           = q_data.last;

endmodule

[tb/tb_midi_track_event_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser_core
// Feeds track chunk byte streams through the parser and checks every record
// against a cycle-free predictor, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser_core;
    import mtep_pkg::*;

    localparam logic [3:0] EK_STRAY = 4'd0;
    localparam logic [3:0] EK_SYSEX = 4'd8;
    localparam logic [3:0] EK_META  = 4'd9;

    localparam int SEL_CHANNEL = 0;
    localparam int SEL_RUNNING = 1;
    localparam int SEL_META    = 2;
    localparam int SEL_SYSEX   = 3;
    localparam int SEL_SYSTEM  = 4;
    localparam int SEL_STRAY   = 5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  record_kind;
    logic [3:0]  event_kind;
    logic [7:0]  status_byte;
    logic [7:0]  meta_code;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic [31:0] delta_ticks;
    logic [31:0] payload_length;
    logic [7:0]  payload_value;
    logic [31:0] chunk_bytes;
    logic        last;

    midi_track_event_parser_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .record_kind(record_kind), .event_kind(event_kind),
        .status_byte(status_byte), .meta_code(meta_code),
        .first_value(first_value), .second_value(second_value),
        .delta_ticks(delta_ticks), .payload_length(payload_length),
        .payload_value(payload_value), .chunk_bytes(chunk_bytes), .last(last)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bit 8 marks a byte that waits until all records have drained
    logic [8:0]  byte_q[$];
    logic [7:0]  body[$];
    int          last_ev_len;
    record_t     record_q[$];
    int          mismatches = 0;
    logic        stim_done = 1'b0;
    logic [7:0]  run_status_gen = 8'd0;

    // parser state mirror
    phase_t      ph;
    logic [2:0]  hdr_idx;
    logic [31:0] decl_len;
    logic [31:0] consumed;
    logic [7:0]  run_status;
    logic [31:0] delta_acc;
    logic [7:0]  cur_status;
    logic [7:0]  cur_meta;
    logic [7:0]  held_v1;
    logic [31:0] pay_left;

    function automatic logic [3:0] event_kind_for(input logic [7:0] st);
        if (st >= STATUS_MIN && st < SYSTEM_MIN)
            return {1'b0, st[6:4]} + 4'd1;
        if (st == SYSEX_START || st == SYSEX_ESC)
            return EK_SYSEX;
        if (st == META_STATUS)
            return EK_META;
        return EK_STRAY;
    endfunction

    function automatic logic single_data(input logic [7:0] st);
        return st[7:4] == 4'hC || st[7:4] == 4'hD;
    endfunction

    task automatic push_record(input logic [1:0] rk, input logic [3:0] ek,
                               input logic [7:0] st, input logic [7:0] mc,
                               input logic [7:0] v1, input logic [7:0] v2,
                               input logic [31:0] dt, input logic [31:0] pl,
                               input logic [7:0] pv, input logic [31:0] cb,
                               input logic lst);
        record_t r;
        r.record_kind = rk;
        r.event_kind = ek;
        r.status_byte = st;
        r.meta_code = mc;
        r.first_value = v1;
        r.second_value = v2;
        r.delta_ticks = dt;
        r.payload_length = pl;
        r.payload_value = pv;
        r.chunk_bytes = cb;
        r.last = lst;
        record_q.push_back(r);
    endtask

    task automatic push_channel(input logic [7:0] v1, input logic [7:0] v2);
        push_record(REC_EVENT, event_kind_for(cur_status), cur_status, 8'd0,
                    v1, v2, delta_acc, 32'd0, 8'd0, 32'd0, 1'b1);
    endtask

    task automatic reset_parser();
        ph = PH_HEADER;
        hdr_idx = '0;
        decl_len = '0;
        consumed = '0;
        run_status = '0;
        delta_acc = '0;
        cur_status = '0;
        cur_meta = '0;
        held_v1 = '0;
        pay_left = '0;
    endtask

    // predict the records that one accepted byte produces
    task automatic parse_byte(input logic [7:0] b);
        logic boundary;
        boundary = 1'b0;
        if (ph != PH_HEADER && consumed != 32'hFFFF_FFFF)
            consumed = consumed + 32'd1;
        case (ph)
            PH_DELTA:
            begin
                delta_acc = {delta_acc[24:0], b[6:0]};
                if (!b[7])
                    ph = PH_STATUS;
            end
            PH_STATUS:
            begin
                cur_meta = 8'd0;
                if (b[7])
                begin
                    cur_status = b;
                    if (b < SYSTEM_MIN)
                    begin
                        run_status = b;
                        ph = PH_DATA1;
                    end
                    else if (b == SYSEX_START || b == SYSEX_ESC)
                    begin
                        pay_left = 32'd0;
                        ph = PH_LENGTH;
                    end
                    else if (b == META_STATUS)
                        ph = PH_METATYPE;
                    else
                    begin
                        push_record(REC_EVENT, EK_STRAY, b, 8'd0, 8'd0, 8'd0,
                                    delta_acc, 32'd0, 8'd0, 32'd0, 1'b1);
                        boundary = 1'b1;
                    end
                end
                else if (run_status != 8'd0)
                begin
                    cur_status = run_status;
                    held_v1 = b;
                    if (single_data(cur_status))
                    begin
                        push_channel(b, 8'd0);
                        boundary = 1'b1;
                    end
                    else
                        ph = PH_DATA2;
                end
                else
                begin
                    cur_status = 8'd0;
                    push_record(REC_EVENT, EK_STRAY, 8'd0, 8'd0, b, 8'd0,
                                delta_acc, 32'd0, 8'd0, 32'd0, 1'b1);
                    boundary = 1'b1;
                end
            end
            PH_DATA1:
            begin
                held_v1 = b;
                if (single_data(cur_status))
                begin
                    push_channel(b, 8'd0);
                    boundary = 1'b1;
                end
                else
                    ph = PH_DATA2;
            end
            PH_DATA2:
            begin
                push_channel(held_v1, b);
                boundary = 1'b1;
            end
            PH_METATYPE:
            begin
                cur_meta = b;
                pay_left = 32'd0;
                ph = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                pay_left = {pay_left[24:0], b[6:0]};
                if (!b[7])
                begin
                    push_record(REC_EVENT, event_kind_for(cur_status), cur_status,
                                cur_meta, 8'd0, 8'd0, delta_acc, pay_left, 8'd0,
                                32'd0, pay_left == 32'd0);
                    if (pay_left == 32'd0)
                        boundary = 1'b1;
                    else
                        ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (pay_left != 32'd0)
                    pay_left = pay_left - 32'd1;
                push_record(REC_PAYLOAD, event_kind_for(cur_status), cur_status,
                            cur_meta, 8'd0, 8'd0, delta_acc, 32'd0, b, 32'd0,
                            pay_left == 32'd0);
                if (pay_left == 32'd0)
                    boundary = 1'b1;
            end
            default:
            begin
                ph = PH_HEADER;
                if (hdr_idx >= 3'd4)
                    decl_len = {decl_len[23:0], b};
                if (hdr_idx == 3'd7)
                begin
                    hdr_idx = 3'd0;
                    consumed = 32'd0;
                    if (decl_len == 32'd0)
                        push_record(REC_END, EK_STRAY, 8'd0, 8'd0, 8'd0, 8'd0,
                                    32'd0, 32'd0, 8'd0, decl_len, 1'b1);
                    else
                    begin
                        delta_acc = 32'd0;
                        ph = PH_DELTA;
                    end
                end
                else
                    hdr_idx = hdr_idx + 3'd1;
            end
        endcase
        // end of chunk check at an event boundary
        if (boundary)
        begin
            if (consumed >= decl_len)
            begin
                push_record(REC_END, EK_STRAY, 8'd0, 8'd0, 8'd0, 8'd0,
                            32'd0, 32'd0, 8'd0, decl_len, 1'b1);
                ph = PH_HEADER;
                hdr_idx = 3'd0;
            end
            else
            begin
                delta_acc = 32'd0;
                ph = PH_DELTA;
            end
        end
    endtask

    // variable length encoding: 0 shortest, 1 zero padded, 2 five groups with junk on top
    task automatic put_vlq(input logic [31:0] v, input int style);
        logic [6:0] grp[$];
        logic [31:0] t;
        t = v;
        if (style == 2)
        begin
            body.push_back({1'b1, 3'($urandom_range(1, 7)), v[31:28]});
            body.push_back({1'b1, v[27:21]});
            body.push_back({1'b1, v[20:14]});
            body.push_back({1'b1, v[13:7]});
            body.push_back({1'b0, v[6:0]});
        end
        else
        begin
            if (style == 1)
                repeat ($urandom_range(1, 2)) body.push_back(8'h80);
            grp.push_front(t[6:0]);
            t = t >> 7;
            while (t != 0)
            begin
                grp.push_front(t[6:0]);
                t = t >> 7;
            end
            while (grp.size() > 1)
                body.push_back({1'b1, grp.pop_front()});
            body.push_back({1'b0, grp.pop_front()});
        end
    endtask

    function automatic logic [7:0] data_val();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic add_event(input int sel, input logic [7:0] st);
        int start;
        int n;
        int r;
        start = body.size();
        r = $urandom_range(0, 19);
        if (r < 12)
            put_vlq($urandom_range(0, 127), 0);
        else if (r < 16)
            put_vlq($urandom, 0);
        else if (r < 18)
            put_vlq($urandom_range(0, 300), 1);
        else
            put_vlq($urandom, 2);
        case (sel)
            SEL_CHANNEL, SEL_RUNNING:
            begin
                if (sel == SEL_CHANNEL)
                begin
                    body.push_back(st);
                    body.push_back(data_val());
                end
                else
                    body.push_back(8'($urandom_range(0, 127)));
                if (!single_data(sel == SEL_CHANNEL ? st : run_status_gen))
                    body.push_back(data_val());
            end
            SEL_META, SEL_SYSEX:
            begin
                body.push_back(st);
                if (sel == SEL_META)
                    body.push_back(8'($urandom));
                n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                r = $urandom_range(0, 9);
                put_vlq(n, r < 7 ? 0 : (r < 9 ? 1 : 2));
                repeat (n) body.push_back(8'($urandom));
            end
            SEL_SYSTEM:
                body.push_back(st);
            default:
                body.push_back(8'($urandom_range(0, 127)));
        endcase
        if (sel == SEL_CHANNEL)
            run_status_gen = st;
        last_ev_len = body.size() - start;
    endtask

    function automatic logic [7:0] system_status();
        logic [7:0] s;
        s = 8'($urandom_range(8'hF1, 8'hFE));
        if (s == SYSEX_ESC)
            s = 8'hF8;
        return s;
    endfunction

    // header plus body onto the byte queue
    task automatic flush_chunk(input logic [31:0] len, input logic drain_first);
        for (int i = 0; i < 4; i++)
            byte_q.push_back({(i == 0) && drain_first, 8'($urandom)});
        for (int i = 3; i >= 0; i--)
            byte_q.push_back({1'b0, len[8*i +: 8]});
        while (body.size() > 0)
            byte_q.push_back({1'b0, body.pop_front()});
    endtask

    task automatic random_chunk();
        int r;
        int k;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 7)
        begin
            flush_chunk(32'd0, $urandom_range(0, 9) == 0);
            return;
        end
        repeat ($urandom_range(1, 8))
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
                add_event(SEL_CHANNEL, 8'($urandom_range(8'h80, 8'hEF)));
            else if (k < 67 && run_status_gen != 8'd0)
                add_event(SEL_RUNNING, 8'd0);
            else if (k < 78)
                add_event(SEL_META, META_STATUS);
            else if (k < 88)
                add_event(SEL_SYSEX, $urandom_range(0, 1) ? SYSEX_START : SYSEX_ESC);
            else
                add_event(SEL_SYSTEM, system_status());
        end
        len = body.size();
        // overrun: the declared length ends inside the last event
        if (r >= 92 && last_ev_len > 1)
            len = len - $urandom_range(1, last_ev_len - 1);
        flush_chunk(len, $urandom_range(0, 9) == 0);
    endtask

    // directed chunks, random ones, then a final directed chunk
    task automatic build_stimulus();
        flush_chunk(32'd0, 1'b0);
        add_event(SEL_STRAY, 8'd0);
        for (int i = 8; i < 15; i++)
            add_event(SEL_CHANNEL, {4'(i), 4'($urandom)});
        add_event(SEL_RUNNING, 8'd0);
        add_event(SEL_META, META_STATUS);
        add_event(SEL_SYSEX, SYSEX_ESC);
        add_event(SEL_SYSTEM, 8'hFE);
        flush_chunk(body.size(), 1'b0);
        while (byte_q.size() < 1150)
            random_chunk();
        // a chunk that never reaches its declared length
        repeat (4) add_event(SEL_CHANNEL, 8'h90);
        flush_chunk(32'hFFFF_FFFF, 1'b1);
    endtask

    // request driver: bursts and gaps, pauses for drain on marked bytes
    int   burst_left = 0;
    int   gap_left = 0;
    logic took = 1'b0;

    always @(negedge clk)
    begin
        logic [8:0] nb;
        if (rst_n && (!in_valid || took))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (byte_q.size() == 0)
            begin
                in_valid <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (byte_q[0][8] && record_q.size() != 0)
                in_valid <= 1'b0;
            else
            begin
                nb = byte_q.pop_front();
                in_valid <= 1'b1;
                data_byte <= nb[7:0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // sink stall pattern
    int rx_cycle = 0;

    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 317) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (rx_cycle % 3) == 0;
            default: out_ready <= $urandom_range(0, 4) != 0;
        endcase
    end

    // monitor: check records, then predict from accepted requests
    always @(posedge clk)
    begin
        record_t got;
        record_t want;
        took <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {record_kind, event_kind, status_byte, meta_code, first_value,
                       second_value, delta_ticks, payload_length, payload_value,
                       chunk_bytes, last};
                if (record_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected record %h", got);
                end
                else
                begin
                    want = record_q.pop_front();
                    if (got.record_kind !== want.record_kind
                        || got.event_kind !== want.event_kind
                        || got.status_byte !== want.status_byte
                        || got.meta_code !== want.meta_code
                        || got.first_value !== want.first_value
                        || got.second_value !== want.second_value
                        || got.delta_ticks !== want.delta_ticks
                        || got.payload_length !== want.payload_length
                        || got.payload_value !== want.payload_value
                        || got.chunk_bytes !== want.chunk_bytes
                        || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("record mismatch: expected %h got %h", want, got);
                    end
                end
            end
            if (in_valid && in_ready)
                parse_byte(data_byte);
        end
    end

    initial
    begin
        reset_parser();
        build_stimulus();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && record_q.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && record_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_front.sv
hw/rtl/mtep_queue.sv
hw/rtl/midi_track_event_parser_core.sv
tb/tb_midi_track_event_parser_core.sv
